// ===== hdl/lzfd_pkg.sv =====
// Package: shared types and constants for the flag-bit LZ decompressor.
package lzfd_pkg;

    localparam int WINDOW_DEPTH_DEFAULT = 8192;
    localparam int OUT_LANES_DEFAULT = 4;
    localparam int SRC_LEN_W = 24;
    localparam int LEFT_W = 25;
    localparam int WORD_W = 32;
    localparam int CNT_W = 3;
    localparam int FLAG_CNT_W = 5;
    localparam int RUN_W = 9;
    localparam int DIST_W = 13;
    localparam logic [7:0] COUNT_MASK = 8'h07;
    localparam logic [7:0] DIST_HI_MASK = 8'hF8;
    localparam int DIST_HI_SHIFT = 5;
    localparam logic [FLAG_CNT_W-1:0] DESC_FLAGS = 5'h10;
    localparam logic [7:0] EXT_END = 8'h00;
    localparam logic [7:0] EXT_SKIP = 8'h01;
    localparam logic [SRC_LEN_W-1:0] USED_MAX = '1;

    typedef enum logic [3:0] {
        PH_DESC_LO,
        PH_DESC_HI,
        PH_FLAG_A,
        PH_FLAG_B,
        PH_FLAG_C1,
        PH_FLAG_C2,
        PH_LITERAL,
        PH_SHORT_DIST,
        PH_LONG_LO,
        PH_LONG_HI,
        PH_EXTEND,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FLAGS,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_FLUSH,
        ST_END
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic take_byte;     // latch input byte, count it
        logic flag_step;     // consume one descriptor flag
        logic copy_start;    // decode latched byte: descriptor, literal or copy command
        logic copy_read;     // issue history read
        logic copy_write;    // write read data
        logic flush;         // emit partial word
        logic emit_end;      // emit end item
        logic mark_last;     // this emission ends the byte's results
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic     out_busy;
        logic     flags_pending;
        logic     copy_left;
        phase_t   phase;
        logic     is_end_byte;
    } status_t;

endpackage

// ===== hdl/lz_flag_bit_decompressor.sv =====
// Top level: flag-bit LZ decompressor, controller plus datapath.
// Usage:
//   source_byte/source_valid/source_stall carries compressed bytes in; a
//   transfer happens when valid is high and stall is low.
//   out_* fields with valid/stall carry result words of up to four bytes,
//   lane zero earliest; run_last marks the last word from one input byte.
//   The end item has end_of_stream set, byte_count zero and source_left
//   holding the budget minus bytes consumed.
//   cfg_valid/cfg_ready/cfg_data write source_length; ready is always high.
// Throughput: one byte at a time. Each byte is taken, then decoded, then its
//   descriptor flags are stepped; a copy then loops over each copied byte
//   (history read then write, then a final check of the remaining count).
// Output: a literal's word is emitted by the flush after its flags are
//   stepped; a copy's first word is emitted once four bytes are written, or
//   by the flush when the copy is shorter than four bytes.
// Reset clears all parser state; the history window holds no valid data
//   until written. After the end item further bytes are taken and dropped.
// When the receiver stalls, the result register holds and the copy loop
//   waits on it; no input is taken until all results of a byte have left.
module lz_flag_bit_decompressor #(
    parameter int WINDOW_DEPTH = lzfd_pkg::WINDOW_DEPTH_DEFAULT,
    parameter int OUT_LANES = lzfd_pkg::OUT_LANES_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lzfd_pkg::SRC_LEN_W-1:0] cfg_data,
    input  logic                          source_valid,
    output logic                          source_stall,
    input  logic [7:0]                    source_byte,
    output logic                          valid,
    input  logic                          stall,
    output logic [lzfd_pkg::WORD_W-1:0]  out_bytes,
    output logic [lzfd_pkg::CNT_W-1:0]   byte_count,
    output logic                          run_last,
    output logic                          end_of_stream,
    output logic signed [lzfd_pkg::LEFT_W-1:0] source_left
);
    import lzfd_pkg::*;

    logic [SRC_LEN_W-1:0] source_length_reg;
    cmd_t cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            source_length_reg <= '0;
        else if (cfg_valid)
            source_length_reg <= cfg_data;
    end

    lzfd_control u_control (
        .clk          (clk),
        .rst_n        (rst_n),
        .source_valid (source_valid),
        .source_stall (source_stall),
        .status       (status),
        .cmd          (cmd)
    );

    lzfd_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .OUT_LANES    (OUT_LANES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .source_byte   (source_byte),
        .source_length (source_length_reg),
        .valid         (valid),
        .stall         (stall),
        .out_bytes     (out_bytes),
        .byte_count    (byte_count),
        .run_last      (run_last),
        .end_of_stream (end_of_stream),
        .source_left   (source_left)
    );

endmodule

// ===== hdl/lzfd_datapath.sv =====
// Datapath: parser registers, history memory, lane packer and output register.
module lzfd_datapath #(
    parameter int WINDOW_DEPTH = lzfd_pkg::WINDOW_DEPTH_DEFAULT,
    parameter int OUT_LANES = lzfd_pkg::OUT_LANES_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lzfd_pkg::cmd_t               cmd,
    output lzfd_pkg::status_t            status,
    input  logic [7:0]                   source_byte,
    input  logic [lzfd_pkg::SRC_LEN_W-1:0] source_length,
    output logic                         valid,
    input  logic                         stall,
    output logic [lzfd_pkg::WORD_W-1:0] out_bytes,
    output logic [lzfd_pkg::CNT_W-1:0]  byte_count,
    output logic                         run_last,
    output logic                         end_of_stream,
    output logic signed [lzfd_pkg::LEFT_W-1:0] source_left
);
    import lzfd_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int LW = $clog2(OUT_LANES + 1);
    localparam int KEEP = (OUT_LANES < 4) ? OUT_LANES : 4;

    logic [7:0] hist_mem [WINDOW_DEPTH];
    logic [7:0] rd_data_reg;
    logic [AW-1:0] wpos_reg, wpos_next;
    logic [15:0] desc_reg, desc_next;
    logic [FLAG_CNT_W-1:0] flags_reg, flags_next;
    phase_t phase_reg, phase_next, resume_reg, resume_next;
    logic [7:0] low_reg, low_next;
    logic [RUN_W-1:0] run_reg, run_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic [SRC_LEN_W-1:0] used_reg, used_next;
    logic [7:0] byte_reg;
    logic [RUN_W-1:0] left_reg, left_next;
    logic [AW-1:0] rd_addr;
    logic [7:0] wr_byte;
    logic wr_en;
    logic [8*OUT_LANES-1:0] lane_reg, lane_next;
    logic [LW-1:0] fill_reg, fill_next;
    logic emit;
    logic [WORD_W-1:0] emit_word;
    logic [CNT_W-1:0] emit_cnt;
    logic valid_reg;
    logic bit0, last_flag;
    phase_t step_to;
    logic [7:0] hb;

    assign hb = byte_reg;
    assign bit0 = desc_reg[0];
    assign last_flag = (flags_reg == FLAG_CNT_W'(1));
    assign rd_addr = wpos_reg - AW'(dist_reg);

    always_comb
    begin
        step_to = PH_FLAG_A;
        case (phase_reg)
            PH_FLAG_A:  step_to = bit0 ? PH_LITERAL : PH_FLAG_B;
            PH_FLAG_B:  step_to = bit0 ? PH_LONG_LO : PH_FLAG_C1;
            PH_FLAG_C1: step_to = PH_FLAG_C2;
            default:    step_to = PH_SHORT_DIST;
        endcase
    end

    always_comb
    begin
        wpos_next = wpos_reg;
        desc_next = desc_reg;
        flags_next = flags_reg;
        phase_next = phase_reg;
        resume_next = resume_reg;
        low_next = low_reg;
        run_next = run_reg;
        dist_next = dist_reg;
        used_next = used_reg;
        left_next = left_reg;
        wr_en = 1'b0;
        wr_byte = byte_reg;
        if (cmd.take_byte && used_reg != USED_MAX)
            used_next = used_reg + 1'b1;
        if (cmd.flag_step)
        begin
            desc_next = desc_reg >> 1;
            flags_next = flags_reg - 1'b1;
            if (phase_reg == PH_FLAG_C1)
                run_next = RUN_W'({bit0, 1'b0});
            else if (phase_reg == PH_FLAG_C2)
                run_next = run_reg | RUN_W'(bit0);
            if (last_flag)
            begin
                resume_next = step_to;
                phase_next = PH_DESC_LO;
            end
            else
                phase_next = step_to;
        end
        if (cmd.copy_start)
        begin
            unique case (phase_reg)
                PH_DESC_LO:
                begin
                    desc_next = {8'h00, hb};
                    phase_next = PH_DESC_HI;
                end
                PH_DESC_HI:
                begin
                    desc_next = {hb, desc_reg[7:0]};
                    flags_next = DESC_FLAGS;
                    phase_next = resume_reg;
                end
                PH_LITERAL:
                begin
                    wr_en = 1'b1;
                    phase_next = PH_FLAG_A;
                end
                PH_SHORT_DIST:
                begin
                    dist_next = DIST_W'(hb);
                    left_next = run_reg + RUN_W'(2);
                    phase_next = PH_FLAG_A;
                end
                PH_LONG_LO:
                begin
                    low_next = hb;
                    phase_next = PH_LONG_HI;
                end
                PH_LONG_HI:
                begin
                    dist_next = {hb[7:3], low_reg};
                    run_next = RUN_W'(hb & COUNT_MASK);
                    if ((hb & COUNT_MASK) != 8'h00)
                    begin
                        left_next = RUN_W'(hb & COUNT_MASK) + RUN_W'(2);
                        phase_next = PH_FLAG_A;
                    end
                    else
                        phase_next = PH_EXTEND;
                end
                PH_EXTEND:
                begin
                    if (hb == EXT_END)
                        phase_next = PH_DONE;
                    else
                    begin
                        if (hb != EXT_SKIP)
                            left_next = RUN_W'(hb) + RUN_W'(1);
                        phase_next = PH_FLAG_A;
                    end
                end
                default: phase_next = PH_FLAG_A;
            endcase
        end
        if (cmd.copy_write)
        begin
            wr_en = 1'b1;
            wr_byte = rd_data_reg;
            left_next = left_reg - 1'b1;
        end
        if (wr_en)
            wpos_next = wpos_reg + 1'b1;
    end

    // lane packer
    always_comb
    begin
        lane_next = lane_reg;
        fill_next = fill_reg;
        emit = 1'b0;
        emit_word = '0;
        emit_cnt = '0;
        if (wr_en)
        begin
            lane_next[8*fill_reg +: 8] = wr_byte;
            fill_next = fill_reg + 1'b1;
        end
        if (cmd.flush || fill_next == LW'(OUT_LANES))
        begin
            emit = (fill_next != '0);
            emit_word = WORD_W'(lane_next[8*KEEP-1:0]);
            emit_cnt = CNT_W'(fill_next);
            lane_next = '0;
            fill_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            hist_mem[wpos_reg] <= wr_byte;
        if (cmd.copy_read)
            rd_data_reg <= hist_mem[rd_addr];
        if (cmd.take_byte)
            byte_reg <= source_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpos_reg <= '0;
            desc_reg <= '0;
            flags_reg <= '0;
            phase_reg <= PH_DESC_LO;
            resume_reg <= PH_FLAG_A;
            low_reg <= '0;
            run_reg <= '0;
            dist_reg <= '0;
            used_reg <= '0;
            left_reg <= '0;
            lane_reg <= '0;
            fill_reg <= '0;
            valid_reg <= 1'b0;
            out_bytes <= '0;
            byte_count <= '0;
            run_last <= 1'b0;
            end_of_stream <= 1'b0;
            source_left <= '0;
        end
        else
        begin
            wpos_reg <= wpos_next;
            desc_reg <= desc_next;
            flags_reg <= flags_next;
            phase_reg <= phase_next;
            resume_reg <= resume_next;
            low_reg <= low_next;
            run_reg <= run_next;
            dist_reg <= dist_next;
            used_reg <= used_next;
            left_reg <= left_next;
            lane_reg <= lane_next;
            fill_reg <= fill_next;
            if (valid_reg && !stall)
                valid_reg <= 1'b0;
            if (emit)
            begin
                valid_reg <= 1'b1;
                out_bytes <= emit_word;
                byte_count <= emit_cnt;
                // a full word on the final copied byte ends the byte's results
                run_last <= cmd.mark_last || (cmd.copy_write && left_next == '0);
                end_of_stream <= 1'b0;
                source_left <= '0;
            end
            else if (cmd.emit_end)
            begin
                valid_reg <= 1'b1;
                out_bytes <= '0;
                byte_count <= '0;
                run_last <= 1'b1;
                end_of_stream <= 1'b1;
                source_left <= LEFT_W'(source_length) - LEFT_W'(used_reg);
            end
        end
    end

    assign valid = valid_reg;

    always_comb
    begin
        status.out_busy = valid_reg && stall;
        status.flags_pending = (flags_reg != '0) &&
            (phase_reg == PH_FLAG_A || phase_reg == PH_FLAG_B ||
             phase_reg == PH_FLAG_C1 || phase_reg == PH_FLAG_C2);
        status.copy_left = (left_reg != '0);
        status.phase = phase_reg;
        status.is_end_byte = (phase_reg == PH_EXTEND) && (byte_reg == EXT_END);
    end

endmodule

// ===== hdl/lzfd_control.sv =====
// Controller: sequences byte intake, flag stepping, copy loop and result emission.
module lzfd_control (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                source_valid,
    output logic                source_stall,
    input  lzfd_pkg::status_t   status,
    output lzfd_pkg::cmd_t      cmd
);
    import lzfd_pkg::*;

    state_t state_reg, state_next;

    // any emission waits until the output register can take it
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (source_valid && status.phase != PH_DONE && !status.out_busy)
                    state_next = ST_END;
            ST_END:
                if (!status.out_busy)
                begin
                    if (status.is_end_byte)
                        state_next = ST_IDLE;
                    else
                        state_next = ST_FLAGS;
                end
            ST_FLAGS:
                if (!status.flags_pending)
                    state_next = status.copy_left ? ST_COPY_RD : ST_FLUSH;
            ST_COPY_RD:
                state_next = status.copy_left ? ST_COPY_WR : ST_FLUSH;
            ST_COPY_WR:
                if (!status.out_busy)
                    state_next = ST_COPY_RD;
            ST_FLUSH:
                if (status.copy_left)
                    state_next = ST_COPY_RD;
                else if (!status.out_busy)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        source_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                // after the end item, transfers are taken and dropped
                source_stall = (status.phase != PH_DONE) && status.out_busy;
                cmd.take_byte = source_valid && !source_stall && status.phase != PH_DONE;
            end
            ST_END:
                if (!status.out_busy)
                begin
                    cmd.copy_start = 1'b1;
                    cmd.emit_end = status.is_end_byte;
                    cmd.mark_last = 1'b0;
                end
            ST_FLAGS:
                cmd.flag_step = status.flags_pending;
            ST_COPY_RD:
                cmd.copy_read = status.copy_left;
            ST_COPY_WR:
                if (!status.out_busy)
                begin
                    cmd.copy_write = 1'b1;
                end
            ST_FLUSH:
                if (!status.out_busy && !status.copy_left)
                begin
                    cmd.flush = 1'b1;
                    cmd.mark_last = 1'b1;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
